/* rtl/pps_pkg.sv */
// Shared constants and field widths for the projection profile segmenter.
package pps_pkg;

  // Configuration port layout and register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Configuration register widths
  localparam int CFG_WIDTH_W  = 8;
  localparam int CFG_HEIGHT_W = 13;

  // Result field widths
  localparam int ROW_W = 12;
  localparam int COL_W = 7;

  // Records emitted per line end, at most
  localparam int MAX_RECORDS = 64;
  localparam int REC_CNT_W   = $clog2(MAX_RECORDS + 1);

endpackage

/* rtl/pps_ifs.sv */
// Request channels of the segmenter: pixel input, record output, register writes.
interface pps_in_if;
  logic valid;
  logic ready;
  logic black;
  modport source (output valid, output black, input ready);
  modport sink (input valid, input black, output ready);
endinterface

interface pps_out_if import pps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] line_top;
  logic [ROW_W-1:0] line_bottom;
  logic [COL_W-1:0] column_left;
  logic [COL_W-1:0] column_right;
  logic             last_of_line;
  modport source (output valid, output line_top, output line_bottom, output column_left,
                  output column_right, output last_of_line, input ready);
  modport sink (input valid, input line_top, input line_bottom, input column_left,
                input column_right, input last_of_line, output ready);
endinterface

interface pps_cfg_if import pps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/pps_ram.sv */
// Generic single-write, single-read RAM with registered read data (read-first).
module pps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/pps_scan.sv */
// Raster scanner: pixel position, row ink tracking, line open/close detection.
module pps_scan import pps_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pps_in_if.sink                            in_chan,
  input  logic                              walk_busy,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
  input  logic [$clog2(MAX_HEIGHT)+1-1:0]   eff_h,
  output logic                              mark_en,
  output logic [$clog2(MAX_WIDTH)-1:0]      mark_addr,
  output logic                              close_valid,
  output logic [$clog2(MAX_HEIGHT)-1:0]     close_top,
  output logic [$clog2(MAX_HEIGHT)-1:0]     close_bottom
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int EHW = YW + 1;

  logic [XW-1:0] pixel_x_r, pixel_x_nxt;
  logic [YW-1:0] pixel_y_r, pixel_y_nxt;
  logic          row_ink_r, row_ink_nxt;
  logic          inside_r, inside_nxt;
  logic [YW-1:0] line_top_r, line_top_nxt;
  logic          accept;
  logic          ink;
  logic          row_end;
  logic          last_row;

  assign in_chan.ready = !walk_busy;
  assign accept        = in_chan.valid && !walk_busy;
  assign ink           = row_ink_r || in_chan.black;
  assign row_end       = (WW'(pixel_x_r) + WW'(1)) >= eff_w;
  assign last_row      = (EHW'(pixel_y_r) + EHW'(1)) >= eff_h;

  // Mark the column of every black pixel
  assign mark_en   = accept && in_chan.black;
  assign mark_addr = pixel_x_r;

  // Top of a line that opens on this very row is the current row
  assign close_top = inside_r ? line_top_r : pixel_y_r;

  // Row-end bookkeeping and line close decision
  always_comb begin
    pixel_x_nxt  = pixel_x_r;
    pixel_y_nxt  = pixel_y_r;
    row_ink_nxt  = row_ink_r;
    inside_nxt   = inside_r;
    line_top_nxt = line_top_r;
    close_valid  = 1'b0;
    close_bottom = pixel_y_r;
    if (accept) begin
      if (row_end) begin
        if (ink) begin
          if (!inside_r) begin
            inside_nxt   = 1'b1;
            line_top_nxt = pixel_y_r;
          end
          if (last_row) begin
            close_valid = 1'b1;
            inside_nxt  = 1'b0;
          end
        end else if (inside_r) begin
          close_valid  = 1'b1;
          close_bottom = pixel_y_r - YW'(1);
          inside_nxt   = 1'b0;
        end
        row_ink_nxt = 1'b0;
        pixel_x_nxt = '0;
        pixel_y_nxt = last_row ? '0 : pixel_y_r + YW'(1);
      end else begin
        row_ink_nxt = ink;
        pixel_x_nxt = pixel_x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_x_r  <= '0;
      pixel_y_r  <= '0;
      row_ink_r  <= 1'b0;
      inside_r   <= 1'b0;
      line_top_r <= '0;
    end else begin
      pixel_x_r  <= pixel_x_nxt;
      pixel_y_r  <= pixel_y_nxt;
      row_ink_r  <= row_ink_nxt;
      inside_r   <= inside_nxt;
      line_top_r <= line_top_nxt;
    end
  end

endmodule

/* rtl/pps_walk.sv */
// Column map walker: reset clearing pass, run extraction, record output register.
module pps_walk import pps_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
  input  logic                           close_valid,
  input  logic [$clog2(MAX_HEIGHT)-1:0]  close_top,
  input  logic [$clog2(MAX_HEIGHT)-1:0]  close_bottom,
  output logic                           busy,
  output logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
  input  logic                           rd_data,
  output logic                           clr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]   clr_addr,
  pps_out_if.source                      out_chan
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam logic [XW-1:0] LAST_COL = XW'(MAX_WIDTH - 1);

  typedef enum logic [4:0] {
    W_CLEAR  = 5'b00001,
    W_IDLE   = 5'b00010,
    W_START  = 5'b00100,
    W_SCAN   = 5'b01000,
    W_FINISH = 5'b10000
  } walk_state_t;

  walk_state_t          state_r, state_nxt;
  logic [XW-1:0]        col_r, col_nxt;
  logic                 in_run_r, in_run_nxt;
  logic [XW-1:0]        run_start_r, run_start_nxt;
  logic [REC_CNT_W-1:0] n_r, n_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [XW-1:0]        pend_left_r, pend_left_nxt;
  logic [XW-1:0]        pend_right_r, pend_right_nxt;
  logic [YW-1:0]        top_r, bottom_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [XW-1:0]        out_left_r, out_right_r;
  logic                 out_last_r;
  logic [YW-1:0]        out_top_r, out_bottom_r;

  logic                 out_free;
  logic                 bit_on;
  logic                 room;
  logic                 push;
  logic                 push_last;

  assign out_free = !out_valid_r || out_chan.ready;
  assign bit_on   = rd_data && (WW'(col_r) < eff_w);
  assign room     = n_r < REC_CNT_W'(MAX_RECORDS);
  assign busy     = (state_r != W_IDLE);

  // Walk sequencer: one column per cycle, holds while a record cannot be pushed
  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    in_run_nxt     = in_run_r;
    run_start_nxt  = run_start_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_left_nxt  = pend_left_r;
    pend_right_nxt = pend_right_r;
    push           = 1'b0;
    push_last      = 1'b0;
    rd_addr        = col_r;
    clr_en         = 1'b0;
    clr_addr       = col_r;
    unique case (state_r)
      W_CLEAR: begin
        clr_en  = 1'b1;
        col_nxt = col_r + XW'(1);
        if (col_r == LAST_COL) begin
          col_nxt   = '0;
          state_nxt = W_IDLE;
        end
      end
      W_IDLE: begin
        if (close_valid) begin
          state_nxt = W_START;
        end
      end
      W_START: begin
        rd_addr        = '0;
        col_nxt        = '0;
        in_run_nxt     = 1'b0;
        n_nxt          = '0;
        pend_valid_nxt = 1'b0;
        state_nxt      = W_SCAN;
      end
      W_SCAN: begin
        if (in_run_r && !bit_on && room && pend_valid_r && !out_free) begin
          // output busy: hold this column and re-read it
          rd_addr = col_r;
        end else begin
          clr_en = 1'b1;
          if (in_run_r && !bit_on) begin
            in_run_nxt = 1'b0;
            if (room) begin
              push           = pend_valid_r;
              pend_valid_nxt = 1'b1;
              pend_left_nxt  = run_start_r;
              pend_right_nxt = col_r - XW'(1);
              n_nxt          = n_r + REC_CNT_W'(1);
            end
          end else if (!in_run_r && bit_on) begin
            in_run_nxt    = 1'b1;
            run_start_nxt = col_r;
          end
          if (col_r == LAST_COL) begin
            state_nxt = W_FINISH;
          end else begin
            col_nxt = col_r + XW'(1);
            rd_addr = col_r + XW'(1);
          end
        end
      end
      W_FINISH: begin
        if (in_run_r) begin
          // run reaching the right edge of the map
          if (!(room && pend_valid_r && !out_free)) begin
            in_run_nxt = 1'b0;
            if (room) begin
              push           = pend_valid_r;
              pend_valid_nxt = 1'b1;
              pend_left_nxt  = run_start_r;
              pend_right_nxt = LAST_COL;
              n_nxt          = n_r + REC_CNT_W'(1);
            end
          end
        end else if (pend_valid_r) begin
          if (out_free) begin
            push           = 1'b1;
            push_last      = 1'b1;
            pend_valid_nxt = 1'b0;
            state_nxt      = W_IDLE;
          end
        end else begin
          state_nxt = W_IDLE;
        end
      end
      default: begin
        state_nxt = W_CLEAR;
        col_nxt   = '0;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= W_CLEAR;
      col_r        <= '0;
      in_run_r     <= 1'b0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      in_run_r     <= in_run_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    run_start_r  <= run_start_nxt;
    pend_left_r  <= pend_left_nxt;
    pend_right_r <= pend_right_nxt;
    if (state_r == W_IDLE && close_valid) begin
      top_r    <= close_top;
      bottom_r <= close_bottom;
    end
    if (push) begin
      out_left_r   <= pend_left_r;
      out_right_r  <= pend_right_r;
      out_last_r   <= push_last;
      out_top_r    <= top_r;
      out_bottom_r <= bottom_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.line_top     = ROW_W'(out_top_r);
  assign out_chan.line_bottom  = ROW_W'(out_bottom_r);
  assign out_chan.column_left  = COL_W'(out_left_r);
  assign out_chan.column_right = COL_W'(out_right_r);
  assign out_chan.last_of_line = out_last_r;

endmodule

/* rtl/projection_profile_segmenter_top.sv */
// Top level of the projection profile segmenter: config registers, map memory, scan and walk.
// Pixels enter one per cycle in raster order while the block scans. At each line end
// (a white row after ink, or the last image row when it holds ink) the input stalls while
// the column occupancy memory is walked one column per cycle, read and cleared through its
// single read and write port; the walk holds longer while the record output is not taken.
// Each run of marked columns gives one record, at most 64 per line. After reset a clearing
// pass sweeps the memory before the first pixel is accepted. Configuration writes are taken
// at any time and should only be made while the block is idle.
module projection_profile_segmenter_top import pps_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  pps_in_if.sink     in_chan,
  pps_out_if.source  out_chan,
  pps_cfg_if.sink    cfg_chan
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int EHW = YW + 1;
  localparam int HCW = (EHW > CFG_HEIGHT_W) ? EHW : CFG_HEIGHT_W;

  logic [CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [CFG_HEIGHT_W-1:0] cfg_height_r;
  logic [WW-1:0]           eff_w;
  logic [EHW-1:0]          eff_h;

  logic          mark_en;
  logic [XW-1:0] mark_addr;
  logic          close_valid;
  logic [YW-1:0] close_top, close_bottom;
  logic          walk_busy;
  logic [XW-1:0] rd_addr;
  logic          rd_data;
  logic          clr_en;
  logic [XW-1:0] clr_addr;

  // Configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_WIDTH_W'(128);
      cfg_height_r <= CFG_HEIGHT_W'(4096);
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == REG_IMAGE_WIDTH) begin
        cfg_width_r <= cfg_chan.data[CFG_WIDTH_W-1:0];
      end
      if (cfg_chan.index == REG_IMAGE_HEIGHT) begin
        cfg_height_r <= cfg_chan.data[CFG_HEIGHT_W-1:0];
      end
    end
  end

  // Clamp the configured size to the supported range
  always_comb begin
    if (cfg_width_r == '0) begin
      eff_w = WW'(1);
    end else if (cfg_width_r > CFG_WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      eff_h = EHW'(1);
    end else if (HCW'(cfg_height_r) > HCW'(MAX_HEIGHT)) begin
      eff_h = EHW'(MAX_HEIGHT);
    end else begin
      eff_h = EHW'(cfg_height_r);
    end
  end

  pps_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .walk_busy    (walk_busy),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .mark_en      (mark_en),
    .mark_addr    (mark_addr),
    .close_valid  (close_valid),
    .close_top    (close_top),
    .close_bottom (close_bottom)
  );

  pps_walk #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .eff_w        (eff_w),
    .close_valid  (close_valid),
    .close_top    (close_top),
    .close_bottom (close_bottom),
    .busy         (walk_busy),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .clr_en       (clr_en),
    .clr_addr     (clr_addr),
    .out_chan     (out_chan)
  );

  // Column occupancy map; marks and clears never fall in the same cycle
  pps_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (mark_en || clr_en),
    .wr_addr (clr_en ? clr_addr : mark_addr),
    .wr_data (mark_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

/* rtl/pps_checker.sv */
// Port-level assertions for the segmenter, bound to the top level.
module pps_checker import pps_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] line_top,
  input logic [ROW_W-1:0] line_bottom,
  input logic [COL_W-1:0] column_left,
  input logic [COL_W-1:0] column_right,
  input logic             last_of_line
);

  // A stalled record stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("record dropped while stalled");

  // A stalled record keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(line_top) && $stable(line_bottom) &&
      $stable(column_left) && $stable(column_right) && $stable(last_of_line))
    else $error("record changed while stalled");

  // Column runs are never reversed
  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> column_left <= column_right)
    else $error("column_left above column_right");

  // Lines are never reversed
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> line_top <= line_bottom)
    else $error("line_top below line_bottom");

endmodule

bind projection_profile_segmenter_top pps_checker u_pps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .line_top     (out_chan.line_top),
  .line_bottom  (out_chan.line_bottom),
  .column_left  (out_chan.column_left),
  .column_right (out_chan.column_right),
  .last_of_line (out_chan.last_of_line)
);
